@@ sv/mtf_pkg.sv @@
// Shared types and constants for the move-to-front ordered table.
package mtf_pkg;

  // Default sizing
  localparam int DEPTH_DEF         = 32;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int REQ_W   = 3;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND     = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_DELETE     = 3'd2,
    REQ_GET        = 3'd3,
    REQ_REVERSE    = 3'd4,
    REQ_PRINT      = 3'd5
  } req_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_GET,
    S_SHIFT,
    S_PUT,
    S_REV_B,
    S_REV_C,
    S_REV_D,
    S_PRINT,
    S_RESP
  } state_t;

  // Input word
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] payload_in;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [WORD_W-1:0]  payload_out;
    logic [POS_W-1:0]   entry_index;
    logic [COUNT_W-1:0] entry_count;
    logic               last_of_run;
  } out_word_t;

endpackage

@@ sv/ordered_list_table_move_to_front_unit.sv @@
// Ordered table with move-to-front access, built around one synchronous memory.
//
// Input channel (in_valid/in_ready/in_data) takes one request word: append,
// push front, delete, get-and-move-to-front, reverse or print prefix.
// Output channel (out_valid/out_ready/out_data) returns one result word per
// request, or position+1 words for a successful print, the final one with
// last_of_run set. Every result carries the entry count after the request.
// Append and errors go straight to the result; push front shifts every entry
// up and writes the head; delete shifts the entries above p down; get reads
// entry p, shifts the ones before it up and writes it to the head; reverse
// swaps entries in pairs; print sends one word per cycle. All shifts and
// swaps go through the single memory port pair, one entry per cycle.
// One request is worked on at a time; a new one is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// A stalled receiver holds the output register; a print run then pauses.
// Reset (rst, synchronous) empties the table and drops any pending result;
// the memory contents are not cleared.
module ordered_list_table_move_to_front_unit
  import mtf_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Entry memory
  logic [PAYLOAD_WIDTH-1:0] mem [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] rdata;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [AW-1:0]            mem_raddr;
  logic [PAYLOAD_WIDTH-1:0] mem_wdata;

  // Sequencer registers
  state_t                   state, state_next;
  state_t                   after, after_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            left, left_next;
  logic [AW-1:0]            src, src_next;
  logic [AW-1:0]            hi, hi_next;
  logic [AW-1:0]            wa, wa_next;
  logic [AW-1:0]            pos_q, pos_q_next;
  logic                     pend, pend_next;
  logic                     dir_up, dir_up_next;
  logic [PAYLOAD_WIDTH-1:0] hold, hold_next;
  status_t                  resp_status, resp_status_next;
  logic [WORD_W-1:0]        resp_payload, resp_payload_next;
  logic [POS_W-1:0]         resp_index, resp_index_next;

  // Output register
  out_word_t                out_next;
  logic                     out_load;
  logic                     out_free;

  // Request decode
  req_t                     req;
  logic [XW-1:0]            pos_x;
  logic [XW-1:0]            cnt_x;
  logic [AW-1:0]            pos_a;
  logic                     pos_bad;
  logic                     is_full;
  logic [AW:0]              lo_plus2;

  assign req      = req_t'(in_data.req_type);
  assign pos_x    = XW'(in_data.position);
  assign cnt_x    = XW'(count);
  assign pos_a    = AW'(pos_x);
  assign pos_bad  = (pos_x >= cnt_x);
  assign is_full  = (count == FULL_CNT);
  assign out_free = !out_valid || out_ready;
  assign lo_plus2 = {1'b0, src} + (AW+1)'(2);

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    after        <= after_next;
    left         <= left_next;
    src          <= src_next;
    hi           <= hi_next;
    wa           <= wa_next;
    pos_q        <= pos_q_next;
    dir_up       <= dir_up_next;
    hold         <= hold_next;
    resp_status  <= resp_status_next;
    resp_payload <= resp_payload_next;
    resp_index   <= resp_index_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // Next state, memory access and result loading
  always_comb begin
    state_next        = state;
    after_next        = after;
    count_next        = count;
    left_next         = left;
    src_next          = src;
    hi_next           = hi;
    wa_next           = wa;
    pos_q_next        = pos_q;
    pend_next         = pend;
    dir_up_next       = dir_up;
    hold_next         = hold;
    resp_status_next  = resp_status;
    resp_payload_next = resp_payload;
    resp_index_next   = resp_index;
    mem_we            = 1'b0;
    mem_waddr         = wa;
    mem_wdata         = hold;
    mem_raddr         = src;
    in_ready          = 1'b0;
    out_load          = 1'b0;
    out_next          = '0;

    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        // get reads its entry right away; reverse and print start at the head
        mem_raddr = (req == REQ_GET) ? pos_a : '0;
        if (in_valid) begin
          resp_status_next  = STAT_OK;
          resp_payload_next = '0;
          resp_index_next   = '0;
          state_next        = S_RESP;
          case (req)
            REQ_APPEND: begin
              if (is_full) begin
                resp_status_next = STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(count);
                mem_wdata  = PAYLOAD_WIDTH'(in_data.payload_in);
                count_next = count + 1'b1;
              end
            end
            REQ_PUSH_FRONT: begin
              if (is_full) begin
                resp_status_next = STAT_FULL;
              end else begin
                hold_next   = PAYLOAD_WIDTH'(in_data.payload_in);
                src_next    = AW'(count - 1'b1);
                left_next   = count;
                dir_up_next = 1'b0;
                pend_next   = 1'b0;
                after_next  = S_PUT;
                count_next  = count + 1'b1;
                state_next  = S_SHIFT;
              end
            end
            REQ_DELETE: begin
              if (pos_bad) begin
                resp_status_next = STAT_BAD_POS;
              end else begin
                src_next    = AW'(pos_x + XW'(1));
                left_next   = CW'(cnt_x - pos_x - XW'(1));
                dir_up_next = 1'b1;
                pend_next   = 1'b0;
                after_next  = S_RESP;
                count_next  = count - 1'b1;
                state_next  = S_SHIFT;
              end
            end
            REQ_GET: begin
              if (pos_bad) begin
                resp_status_next = STAT_BAD_POS;
              end else begin
                pos_q_next = pos_a;
                state_next = S_GET;
              end
            end
            REQ_REVERSE: begin
              if (count > CW'(1)) begin
                src_next   = '0;
                hi_next    = AW'(count - 1'b1);
                pend_next  = 1'b0;
                state_next = S_REV_B;
              end
            end
            REQ_PRINT: begin
              if (pos_bad) begin
                resp_status_next = STAT_BAD_POS;
              end else begin
                pos_q_next = pos_a;
                src_next   = '0;
                state_next = S_PRINT;
              end
            end
            default: begin
              resp_status_next = STAT_OK;
            end
          endcase
        end
      end

      // Entry read done: keep it and shift the entries before it up by one
      S_GET: begin
        hold_next         = rdata;
        resp_payload_next = WORD_W'(rdata);
        resp_index_next   = POS_W'(pos_q);
        src_next          = pos_q - 1'b1;
        left_next         = CW'(pos_q);
        dir_up_next       = 1'b0;
        pend_next         = 1'b0;
        after_next        = S_PUT;
        state_next        = S_SHIFT;
      end

      // Pipelined move: write last cycle's read while reading the next entry
      S_SHIFT: begin
        mem_we    = pend;
        mem_waddr = wa;
        mem_wdata = rdata;
        mem_raddr = src;
        if (left != '0) begin
          pend_next = 1'b1;
          wa_next   = dir_up ? src - 1'b1 : src + 1'b1;
          src_next  = dir_up ? src + 1'b1 : src - 1'b1;
          left_next = left - 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = after;
        end
      end

      // Head write for push front and move to front
      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = hold;
        state_next = S_RESP;
      end

      // Reverse: low entry arrives, read the high one, finish the last swap
      S_REV_B: begin
        mem_we     = pend;
        mem_waddr  = wa;
        mem_wdata  = hold;
        hold_next  = rdata;
        mem_raddr  = hi;
        state_next = S_REV_C;
      end

      // Reverse: high entry goes low, read the next low entry
      S_REV_C: begin
        mem_we    = 1'b1;
        mem_waddr = src;
        mem_wdata = rdata;
        wa_next   = hi;
        pend_next = 1'b1;
        src_next  = src + 1'b1;
        hi_next   = hi - 1'b1;
        mem_raddr = src + 1'b1;
        if (lo_plus2 < {1'b0, hi}) begin
          state_next = S_REV_B;
        end else begin
          state_next = S_REV_D;
        end
      end

      // Reverse: last low entry goes high
      S_REV_D: begin
        mem_we     = 1'b1;
        mem_waddr  = wa;
        mem_wdata  = hold;
        pend_next  = 1'b0;
        state_next = S_RESP;
      end

      // Print: one word per cycle while the output register is free
      S_PRINT: begin
        mem_raddr = src;
        if (out_free) begin
          out_load             = 1'b1;
          out_next.status      = STAT_OK;
          out_next.payload_out = WORD_W'(rdata);
          out_next.entry_index = POS_W'(src);
          out_next.entry_count = COUNT_W'(count);
          out_next.last_of_run = (src == pos_q);
          if (src == pos_q) begin
            state_next = S_IDLE;
          end else begin
            src_next  = src + 1'b1;
            mem_raddr = src + 1'b1;
          end
        end
      end

      // Single result of the request
      S_RESP: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next.status      = resp_status;
          out_next.payload_out = resp_payload;
          out_next.entry_index = resp_index;
          out_next.entry_count = COUNT_W'(count);
          out_next.last_of_run = 1'b1;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/mtf_checker.sv @@
// Port-level checks for the move-to-front table, bound to the top level.
module mtf_checker
  import mtf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Error results stand alone and carry no entry
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STAT_OK) |->
      out_data.last_of_run && (out_data.payload_out == '0) && (out_data.entry_index == '0))
    else $error("error result is not a lone empty word");

  // Full status only when the table holds DEPTH entries
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STAT_FULL) |->
      out_data.entry_count == COUNT_W'(DEPTH))
    else $error("full status with table not full");

  // A waiting request word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request word changed while waiting");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ordered_list_table_move_to_front_unit mtf_checker #(.DEPTH(DEPTH)) u_mtf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
